// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the console writer RTL.
// Depends on nothing; each use names its clock and active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define TCW_ASSERT(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When trig holds, resp must hold in the next cycle.
`define TCW_ASSERT_NEXT(label, clk, rst_n, trig, resp, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (resp)) \
        else $error(msg);

`endif

// ----- hdl/tcw_pkg.sv -----
// Constants and types of the text console writer.
// No dependencies; imported by text_console_writer.
package tcw_pkg;

    localparam int SCREEN_ROWS    = 25;
    localparam int SCREEN_COLUMNS = 80;
    localparam int CELL_COUNT     = SCREEN_ROWS * SCREEN_COLUMNS;
    localparam int MOVE_COUNT     = CELL_COUNT - SCREEN_COLUMNS;
    localparam int LAST_ROW_BASE  = (SCREEN_ROWS - 1) * SCREEN_COLUMNS;

    localparam int ADDR_W   = $clog2(CELL_COUNT);
    localparam int ROW_W    = 5;
    localparam int COL_W    = 7;
    localparam int BYTE_W   = 8;
    localparam int COLOUR_W = 4;
    localparam int CELL_W   = 2 * BYTE_W;

    localparam logic [BYTE_W-1:0] BLANK_BYTE   = 8'd32;
    localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'd10;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic CFG_FOREGROUND = 1'b0;
    localparam logic CFG_BACKGROUND = 1'b1;

    localparam logic [COLOUR_W-1:0] FOREGROUND_RESET = 4'd15;
    localparam logic [COLOUR_W-1:0] BACKGROUND_RESET = 4'd0;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CELL_W-1:0] t_cell;

endpackage

// ----- hdl/text_console_writer.sv -----
// Text console writer: 25x80 cell screen memory with cursor, put/clear/read.
// Depends on tcw_pkg and assert_macros.svh.
//
//  channel   direction  handshake                      word
//  command   in         i_start && !o_busy             opcode, char, read row/column
//  result    out        o_valid (one-cycle strobe)      cursor row/column, cell char/colour
//  config    in         i_cfg_valid && o_cfg_ready     index 0 fg, 1 bg, 4-bit data
//
// Put of a character: strobe registered from S_EXEC; read: from S_RDWAIT after the read port.
// Newline or wrap on the last row: scroll copies 1920 cells through the single
// read port, one a cycle, then a last write-back drains and the fill blanks 80.
// Clear blanks all 2000 cells. Next word can be taken in the cycle of the strobe.
// Reset clears cursor and control; screen memory holds garbage until written.
// o_busy stays high until the result strobe; results cannot be stalled.
`include "assert_macros.svh"

module text_console_writer
    import tcw_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic [1:0]          i_opcode,
    input  logic [BYTE_W-1:0]   i_char_code,
    input  logic [ROW_W-1:0]    i_read_row,
    input  logic [COL_W-1:0]    i_read_column,
    output logic                o_valid,
    output logic [ROW_W-1:0]    o_cursor_row_out,
    output logic [COL_W-1:0]    o_cursor_column_out,
    output logic [BYTE_W-1:0]   o_cell_char,
    output logic [BYTE_W-1:0]   o_cell_colour,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [COLOUR_W-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCROLL,
        S_FILL,
        S_RDWAIT
    } t_state;

    t_state r_state, n_state;

    logic [1:0]          r_op, n_op;
    logic [BYTE_W-1:0]   r_ch, n_ch;
    logic [ROW_W-1:0]    r_rr, n_rr;
    logic [COL_W-1:0]    r_rc, n_rc;
    logic [ROW_W-1:0]    r_row, n_row;
    logic [COL_W-1:0]    r_col, n_col;
    logic [COLOUR_W-1:0] r_fg, r_bg;
    t_addr               r_addr, n_addr;
    t_addr               r_wa, n_wa;
    logic                r_mv, n_mv;
    logic                r_put_after, n_put_after;
    logic                r_valid, n_valid;
    logic [BYTE_W-1:0]   r_cell_char, n_cell_char;
    logic [BYTE_W-1:0]   r_cell_colour, n_cell_colour;

    // screen memory, one write and one registered read port
    t_cell mem [CELL_COUNT];
    t_cell rd_data;
    logic  mem_we, mem_re;
    t_addr mem_wa, mem_ra;
    t_cell mem_wd;

    logic  last_row, line_full, rd_in_range;
    t_cell blank_cell, char_cell;

    function automatic t_addr row_base(input logic [ROW_W-1:0] row);
        return ADDR_W'(row) * ADDR_W'(SCREEN_COLUMNS);
    endfunction

    assign blank_cell  = {r_bg, r_fg, BLANK_BYTE};
    assign char_cell   = {r_bg, r_fg, r_ch};
    assign last_row    = (int'(r_row) == SCREEN_ROWS - 1);
    assign line_full   = (int'(r_col) >= SCREEN_COLUMNS);
    assign rd_in_range = (int'(r_rr) < SCREEN_ROWS) && (int'(r_rc) < SCREEN_COLUMNS);

    always_comb begin
        n_state       = r_state;
        n_op          = r_op;
        n_ch          = r_ch;
        n_rr          = r_rr;
        n_rc          = r_rc;
        n_row         = r_row;
        n_col         = r_col;
        n_addr        = r_addr;
        n_wa          = r_wa;
        n_mv          = r_mv;
        n_put_after   = r_put_after;
        n_valid       = 1'b0;
        n_cell_char   = r_cell_char;
        n_cell_colour = r_cell_colour;
        mem_we        = 1'b0;
        mem_wa        = '0;
        mem_wd        = '0;
        mem_re        = 1'b0;
        mem_ra        = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op    = i_opcode;
                    n_ch    = i_char_code;
                    n_rr    = i_read_row;
                    n_rc    = i_read_column;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_cell_char   = '0;
                n_cell_colour = '0;
                case (r_op)
                    OP_PUT: begin
                        n_put_after = 1'b0;
                        n_addr      = '0;
                        n_mv        = 1'b0;
                        if (r_ch == NEWLINE_BYTE) begin
                            n_col = '0;
                            if (last_row) begin
                                n_state = S_SCROLL;
                            end else begin
                                n_row   = r_row + 1'b1;
                                n_valid = 1'b1;
                                n_state = S_IDLE;
                            end
                        end else if (line_full) begin
                            n_col = COL_W'(1);
                            if (last_row) begin
                                // char lands at column 0 of the bottom row during the fill
                                n_put_after = 1'b1;
                                n_state     = S_SCROLL;
                            end else begin
                                mem_we  = 1'b1;
                                mem_wa  = row_base(r_row + 1'b1);
                                mem_wd  = char_cell;
                                n_row   = r_row + 1'b1;
                                n_valid = 1'b1;
                                n_state = S_IDLE;
                            end
                        end else begin
                            mem_we  = 1'b1;
                            mem_wa  = row_base(r_row) + ADDR_W'(r_col);
                            mem_wd  = char_cell;
                            n_col   = r_col + 1'b1;
                            n_valid = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                    OP_CLEAR: begin
                        n_put_after = 1'b0;
                        n_addr      = '0;
                        n_state     = S_FILL;
                    end
                    OP_READ: begin
                        if (rd_in_range) begin
                            mem_re  = 1'b1;
                            mem_ra  = row_base(r_rr) + ADDR_W'(r_rc);
                            n_state = S_RDWAIT;
                        end else begin
                            n_valid = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                    default: begin
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_SCROLL: begin
                // write back the word read last cycle, one row lower in address
                if (r_mv) begin
                    mem_we = 1'b1;
                    mem_wa = r_wa;
                    mem_wd = rd_data;
                end
                if (int'(r_addr) < MOVE_COUNT) begin
                    mem_re = 1'b1;
                    mem_ra = r_addr + ADDR_W'(SCREEN_COLUMNS);
                    n_mv   = 1'b1;
                    n_wa   = r_addr;
                    n_addr = r_addr + 1'b1;
                end else begin
                    n_mv    = 1'b0;
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                mem_we = 1'b1;
                mem_wa = r_addr;
                if (r_put_after && int'(r_addr) == LAST_ROW_BASE) begin
                    mem_wd = char_cell;
                end else begin
                    mem_wd = blank_cell;
                end
                if (int'(r_addr) == CELL_COUNT - 1) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_RDWAIT: begin
                n_cell_char   = rd_data[BYTE_W-1:0];
                n_cell_colour = rd_data[CELL_W-1:BYTE_W];
                n_valid       = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row       <= '0;
            r_col       <= '0;
            r_fg        <= FOREGROUND_RESET;
            r_bg        <= BACKGROUND_RESET;
            r_addr      <= '0;
            r_mv        <= 1'b0;
            r_put_after <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_addr      <= n_addr;
            r_mv        <= n_mv;
            r_put_after <= n_put_after;
            r_valid     <= n_valid;
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_FOREGROUND) begin
                    r_fg <= i_cfg_data;
                end else begin
                    r_bg <= i_cfg_data;
                end
            end
        end
        r_op          <= n_op;
        r_ch          <= n_ch;
        r_rr          <= n_rr;
        r_rc          <= n_rc;
        r_wa          <= n_wa;
        r_cell_char   <= n_cell_char;
        r_cell_colour <= n_cell_colour;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rd_data <= mem[mem_ra];
        end
    end

    assign o_busy              = (r_state != S_IDLE);
    assign o_cfg_ready         = 1'b1;
    assign o_valid             = r_valid;
    assign o_cursor_row_out    = r_row;
    assign o_cursor_column_out = r_col;
    assign o_cell_char         = r_cell_char;
    assign o_cell_colour       = r_cell_colour;

    `TCW_ASSERT(a_row_range, i_clk, i_rst_n, int'(r_row) < SCREEN_ROWS, "cursor row out of range")
    `TCW_ASSERT(a_col_range, i_clk, i_rst_n, int'(r_col) <= SCREEN_COLUMNS, "cursor column out of range")
    `TCW_ASSERT(a_idle_no_write, i_clk, i_rst_n, !(r_state == S_IDLE && mem_we), "memory write while idle")
    `TCW_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy && !o_valid, "accept did not start work")
    `TCW_ASSERT_NEXT(a_strobe_idle, i_clk, i_rst_n, n_valid, !o_busy, "result strobe while still busy")

endmodule

// ----- sim/tcw_checker.sv -----
// Scoreboard for the text console writer: mirrors screen, cursor and colours,
// predicts every result word and compares it with the strobed outputs.
// Depends on tcw_pkg; instantiated beside the block by tb.
`timescale 1ns / 1ps

module tcw_checker
    import tcw_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_busy,
    input  logic [1:0]          i_opcode,
    input  logic [BYTE_W-1:0]   i_char_code,
    input  logic [ROW_W-1:0]    i_read_row,
    input  logic [COL_W-1:0]    i_read_column,
    input  logic                i_valid,
    input  logic [ROW_W-1:0]    i_cursor_row_out,
    input  logic [COL_W-1:0]    i_cursor_column_out,
    input  logic [BYTE_W-1:0]   i_cell_char,
    input  logic [BYTE_W-1:0]   i_cell_colour,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [COLOUR_W-1:0] i_cfg_data,
    output int                  o_errors,
    output int                  o_pending
);

    typedef struct {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  column;
        logic [BYTE_W-1:0] glyph;
        logic [BYTE_W-1:0] attr;
    } t_console_reply;

    t_cell               screen [CELL_COUNT];
    int                  cur_row;
    int                  cur_col;
    logic [COLOUR_W-1:0] fg;
    logic [COLOUR_W-1:0] bg;
    int                  mismatches;
    t_console_reply      reply_q [$];

    function automatic t_cell styled(input logic [BYTE_W-1:0] glyph);
        return {bg, fg, glyph};
    endfunction

    // Newline: next row, or scroll up and blank the bottom row on the last one.
    task automatic line_feed();
        cur_col = 0;
        if (cur_row + 1 < SCREEN_ROWS) begin
            cur_row++;
        end else begin
            for (int i = 0; i < MOVE_COUNT; i++)
                screen[i] = screen[i + SCREEN_COLUMNS];
            for (int c = 0; c < SCREEN_COLUMNS; c++)
                screen[LAST_ROW_BASE + c] = styled(BLANK_BYTE);
        end
    endtask

    task automatic predict_reply(input logic [1:0] op, input logic [BYTE_W-1:0] glyph,
                                 input logic [ROW_W-1:0] rr, input logic [COL_W-1:0] rc,
                                 output t_console_reply rep);
        t_cell entry;
        entry = '0;
        case (op)
            OP_PUT: begin
                if (glyph == NEWLINE_BYTE) begin
                    line_feed();
                end else begin
                    // full line wraps before the write
                    if (cur_col >= SCREEN_COLUMNS)
                        line_feed();
                    screen[cur_row * SCREEN_COLUMNS + cur_col] = styled(glyph);
                    cur_col++;
                end
            end
            OP_CLEAR: begin
                for (int i = 0; i < CELL_COUNT; i++)
                    screen[i] = styled(BLANK_BYTE);
            end
            OP_READ: begin
                if (int'(rr) < SCREEN_ROWS && int'(rc) < SCREEN_COLUMNS)
                    entry = screen[int'(rr) * SCREEN_COLUMNS + int'(rc)];
            end
            default: ;
        endcase
        rep.row    = cur_row[ROW_W-1:0];
        rep.column = cur_col[COL_W-1:0];
        rep.glyph  = entry[BYTE_W-1:0];
        rep.attr   = entry[CELL_W-1:BYTE_W];
    endtask

    task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                               input logic [BYTE_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_console_reply want;
        t_console_reply next;
        if (!i_rst_n) begin
            cur_row    = 0;
            cur_col    = 0;
            fg         = FOREGROUND_RESET;
            bg         = BACKGROUND_RESET;
            mismatches = 0;
            reply_q.delete();
            o_errors  <= 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_FOREGROUND)
                    fg = i_cfg_data;
                else
                    bg = i_cfg_data;
            end
            if (i_valid) begin
                if (reply_q.size() == 0) begin
                    $error("result word with nothing expected");
                    mismatches++;
                end else begin
                    want = reply_q.pop_front();
                    check_field("cursor_row_out", BYTE_W'(want.row), BYTE_W'(i_cursor_row_out));
                    check_field("cursor_column_out", BYTE_W'(want.column),
                                BYTE_W'(i_cursor_column_out));
                    check_field("cell_char", want.glyph, i_cell_char);
                    check_field("cell_colour", want.attr, i_cell_colour);
                end
            end
            if (i_start && !i_busy) begin
                predict_reply(i_opcode, i_char_code, i_read_row, i_read_column, next);
                reply_q.push_back(next);
            end
            o_pending <= reply_q.size();
            o_errors  <= mismatches;
        end
    end

endmodule

// ----- sim/tb.sv -----
// Testbench top for text_console_writer: clock, reset, command and colour
// stimulus, watchdog and verdict. Depends on tcw_pkg and tcw_checker.
`timescale 1ns / 1ps

module tb;
    import tcw_pkg::*;

    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int ITEM_TARGET  = 500;
    localparam int PHASE_ITEMS  = 50;
    localparam int QUIET_TAIL   = 420;
    // a scroll or clear keeps the block busy while it walks the screen memory
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 16;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_start = 1'b0;
    logic                o_busy;
    logic [1:0]          i_opcode = '0;
    logic [BYTE_W-1:0]   i_char_code = '0;
    logic [ROW_W-1:0]    i_read_row = '0;
    logic [COL_W-1:0]    i_read_column = '0;
    logic                o_valid;
    logic [ROW_W-1:0]    o_cursor_row_out;
    logic [COL_W-1:0]    o_cursor_column_out;
    logic [BYTE_W-1:0]   o_cell_char;
    logic [BYTE_W-1:0]   o_cell_colour;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic                i_cfg_index = 1'b0;
    logic [COLOUR_W-1:0] i_cfg_data = '0;

    int fail_count;
    int pending_count;
    int item_count = 0;
    int quiet_cycles = 0;
    bit idle_on = 1'b1;

    always #2 i_clk = ~i_clk;

    text_console_writer dut (.*);

    tcw_checker checker_i (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_start             (i_start),
        .i_busy              (o_busy),
        .i_opcode            (i_opcode),
        .i_char_code         (i_char_code),
        .i_read_row          (i_read_row),
        .i_read_column       (i_read_column),
        .i_valid             (o_valid),
        .i_cursor_row_out    (o_cursor_row_out),
        .i_cursor_column_out (o_cursor_column_out),
        .i_cell_char         (o_cell_char),
        .i_cell_colour       (o_cell_colour),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .o_errors            (fail_count),
        .o_pending           (pending_count)
    );

    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int idle_gap();
        if (idle_on && $urandom_range(0, 3) == 0)
            return $urandom_range(1, 12);
        return 0;
    endfunction

    function automatic logic [BYTE_W-1:0] random_glyph();
        logic [BYTE_W-1:0] g;
        do g = BYTE_W'($urandom_range(0, 255)); while (g == NEWLINE_BYTE);
        return g;
    endfunction

    function automatic logic [ROW_W-1:0] pick_row();
        case ($urandom_range(0, 7))
            0:       return ROW_W'($urandom_range(SCREEN_ROWS, 31));
            1, 2:    return ROW_W'($urandom_range(SCREEN_ROWS - 2, SCREEN_ROWS - 1));
            default: return ROW_W'($urandom_range(0, SCREEN_ROWS - 1));
        endcase
    endfunction

    function automatic logic [COL_W-1:0] pick_column();
        case ($urandom_range(0, 7))
            0:       return COL_W'($urandom_range(SCREEN_COLUMNS, 127));
            1, 2:    return COL_W'($urandom_range(0, 9));
            default: return COL_W'($urandom_range(0, SCREEN_COLUMNS - 1));
        endcase
    endfunction

    function automatic logic [COLOUR_W-1:0] pick_colour();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return COLOUR_W'($urandom_range(0, 15));
        endcase
    endfunction

    // Returns just after the edge at which the command word was taken.
    task automatic send_op(input logic [1:0] op, input logic [BYTE_W-1:0] glyph,
                           input logic [ROW_W-1:0] rr, input logic [COL_W-1:0] rc);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start       <= 1'b1;
        i_opcode      <= op;
        i_char_code   <= glyph;
        i_read_row    <= rr;
        i_read_column <= rc;
        do @(posedge i_clk); while (o_busy);
        if (op != OP_SPARE)
            item_count++;
    endtask

    task automatic put_char(input logic [BYTE_W-1:0] glyph);
        send_op(OP_PUT, glyph, ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127)));
    endtask

    task automatic read_cell(input logic [ROW_W-1:0] rr, input logic [COL_W-1:0] rc);
        send_op(OP_READ, BYTE_W'($urandom_range(0, 255)), rr, rc);
    endtask

    task automatic clear_screen();
        send_op(OP_CLEAR, BYTE_W'($urandom_range(0, 255)), ROW_W'($urandom_range(0, 31)),
                COL_W'($urandom_range(0, 127)));
    endtask

    // Colour writes only once every outstanding result has come back.
    task automatic write_reg(input logic idx, input logic [COLOUR_W-1:0] data);
        i_start <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic recolour();
        int pick;
        pick = $urandom_range(0, 2);
        if (pick != 1)
            write_reg(CFG_FOREGROUND, pick_colour());
        if (pick != 0)
            write_reg(CFG_BACKGROUND, pick_colour());
    endtask

    initial begin
        int next_phase;
        int kind;
        int n;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_reg(CFG_FOREGROUND, 4'd0);
        write_reg(CFG_BACKGROUND, 4'd15);

        // directed: clear first so no read ever meets an unwritten cell
        clear_screen();
        read_cell(5'd0, 7'd0);
        read_cell(ROW_W'(SCREEN_ROWS - 1), COL_W'(SCREEN_COLUMNS - 1));
        put_char(8'h00);
        put_char(8'hFF);
        put_char(8'h41);
        read_cell(5'd0, 7'd0);
        read_cell(5'd0, 7'd1);
        read_cell(5'd0, 7'd2);
        read_cell(ROW_W'(SCREEN_ROWS), 7'd0);
        read_cell(5'd0, COL_W'(SCREEN_COLUMNS));
        read_cell(5'h1F, 7'h7F);
        send_op(OP_SPARE, 8'hFF, 5'h1F, 7'h7F);
        put_char(NEWLINE_BYTE);
        put_char(BLANK_BYTE);
        write_reg(CFG_FOREGROUND, 4'd15);
        write_reg(CFG_BACKGROUND, 4'd0);
        clear_screen();
        read_cell(5'd1, 7'd0);
        read_cell(5'd0, 7'd2);

        next_phase = item_count + PHASE_ITEMS;
        while (item_count < ITEM_TARGET) begin
            if (item_count >= next_phase) begin
                recolour();
                idle_on = ($urandom_range(0, 3) != 0);
                next_phase += PHASE_ITEMS;
            end
            if (item_count >= QUIET_TAIL)
                idle_on = 1'b0;
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
                // line of text, sometimes long enough to fill and wrap
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(75, 90) : $urandom_range(0, 8);
                repeat (n) begin
                    put_char(random_glyph());
                    if ($urandom_range(0, 5) == 0)
                        read_cell(pick_row(), pick_column());
                end
                if ($urandom_range(0, 4) != 0)
                    put_char(NEWLINE_BYTE);
            end else if (kind < 70) begin
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 30) : $urandom_range(1, 6);
                repeat (n) put_char(NEWLINE_BYTE);
            end else if (kind < 90) begin
                repeat ($urandom_range(1, 4)) read_cell(pick_row(), pick_column());
            end else if (kind < 95) begin
                clear_screen();
            end else begin
                send_op(OP_SPARE, BYTE_W'($urandom_range(0, 255)),
                        ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127)));
            end
        end

        i_start <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
